/* sv/pctp_pkg.sv */
// shared types and constants of the piecewise cubic temperature profile
// no dependencies
`timescale 1ns / 1ps

package pctp_pkg;

  localparam int TW  = 16;   // temperature word
  localparam int ZW  = 17;   // clamped mixture fraction and fraction registers
  localparam int MW  = 32;   // line slopes
  localparam int RW  = 34;   // blend reciprocal
  localparam int CW  = 42;   // cubic coefficients
  localparam int IW  = 20;   // input mixture fraction
  localparam int SLW = 24;   // output slope
  localparam int CIW = 3;    // config index
  localparam int CDW = 17;   // config data

  localparam logic [ZW-1:0] ONE_Z = 17'h10000;

  localparam logic [1:0] BR_LEFT  = 2'd0;
  localparam logic [1:0] BR_BLEND = 2'd1;
  localparam logic [1:0] BR_RIGHT = 2'd2;

  typedef struct packed {
    logic [TW-1:0]        tu;
    logic signed [MW-1:0] m1;
    logic signed [MW-1:0] m2;
    logic [RW-1:0]        recip;
    logic signed [CW-1:0] c0;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
    logic signed [CW-1:0] c3;
    logic                 bad;
  } coef_t;

  typedef struct packed {
    logic [ZW-1:0] a;
    logic [ZW-1:0] b;
  } bounds_t;

  typedef struct packed {
    logic [1:0]    br;
    logic [ZW-1:0] x;
  } mq_word_t;

endpackage

/* sv/pctp_cfg.sv */
// configuration registers and coefficient sequencer
// shared restoring divider and one multiplier; depends on pctp_pkg
`timescale 1ns / 1ps

module pctp_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pctp_pkg::CIW-1:0]   cfg_index,
  input  logic [pctp_pkg::CDW-1:0]   cfg_wdata,
  output logic                       busy,
  output pctp_pkg::coef_t            coef,
  output pctp_pkg::bounds_t          bnd
);

  localparam logic [2:0] REG_TU = 3'd0;
  localparam logic [2:0] REG_TP = 3'd1;
  localparam logic [2:0] REG_ZS = 3'd2;
  localparam logic [2:0] REG_BS = 3'd3;
  localparam logic [2:0] REG_BE = 3'd4;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_PAB   = 4'd4;
  localparam logic [3:0] ST_D     = 4'd5;
  localparam logic [3:0] ST_E     = 4'd6;
  localparam logic [3:0] ST_RND   = 4'd7;

  localparam logic [1:0] DIV_M1 = 2'd0;
  localparam logic [1:0] DIV_M2 = 2'd1;
  localparam logic [1:0] DIV_RC = 2'd2;

  localparam logic [2:0] MUL_PA = 3'd0;
  localparam logic [2:0] MUL_PB = 3'd1;
  localparam logic [2:0] MUL_E1 = 3'd2;
  localparam logic [2:0] MUL_T2 = 3'd3;
  localparam logic [2:0] MUL_T3 = 3'd4;

  localparam logic [16:0] ONE_Z_EXT = pctp_pkg::ONE_Z;

  logic [15:0] tu_r, tp_r;
  logic [16:0] zs_r, a_r, b_r;
  logic [3:0]  st_r;
  logic [1:0]  dsel_r;
  logic [5:0]  dcnt_r;
  logic [16:0] rem_r;
  logic [33:0] quo_r;
  logic [16:0] dvs_r;
  logic        dneg_r;
  logic [2:0]  msel_r;
  logic signed [31:0] m1_r, m2_r;
  logic [33:0] recip_r;
  logic signed [55:0] pa_r, pb_r, e1_r, t2_r, t3_r, d_r;
  logic signed [55:0] e_r [4];
  logic signed [41:0] c_r [4];
  logic        bad_r;

  logic signed [16:0] dt;
  logic [16:0] dt_abs;
  logic signed [17:0] den2;
  logic [17:0] den2_abs;
  logic [16:0] h;
  logic        degen;
  logic [18:0] tr;
  logic        tr_ok;
  logic [33:0] q_fin;
  logic [30:0] q_sat;
  logic signed [31:0] m_val;
  logic [33:0] dvd1, dvd2;
  logic signed [33:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [52:0] mul_p;
  logic signed [55:0] prod;
  logic signed [55:0] tu56;

  function automatic logic signed [41:0] rcoef(input logic signed [55:0] e);
    logic [55:0] mg;
    logic [56:0] sm;
    logic [48:0] r;
    logic [40:0] rc;
    mg = e[55] ? 56'(-e) : 56'(e);
    sm = {1'b0, mg} + 57'd128;
    r  = sm[56:8];
    rc = (r > 49'h100_0000_0000) ? 41'h100_0000_0000 : r[40:0];
    return e[55] ? -$signed({1'b0, rc}) : $signed({1'b0, rc});
  endfunction

  always_comb begin
    dt       = $signed({1'b0, tp_r}) - $signed({1'b0, tu_r});
    dt_abs   = dt[16] ? 17'(-dt) : 17'(dt);
    den2     = $signed({1'b0, ONE_Z_EXT}) - $signed({1'b0, zs_r});
    den2_abs = den2[17] ? 18'(-den2) : 18'(den2);
    h        = b_r - a_r;
    degen    = (zs_r == 17'd0) || (zs_r == pctp_pkg::ONE_Z) || (a_r >= b_r);
    tr       = {1'b0, rem_r, quo_r[33]} - {2'b0, dvs_r};
    tr_ok    = !tr[18];
    q_fin    = {quo_r[32:0], tr_ok};
    q_sat    = (q_fin > 34'h7FFF_FFFF) ? 31'h7FFF_FFFF : q_fin[30:0];
    m_val    = dneg_r ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
    dvd1     = {1'b0, dt_abs, 16'b0} + {18'b0, zs_r[16:1]};
    dvd2     = {1'b0, dt_abs, 16'b0} + {17'b0, den2_abs[17:1]};
    tu56     = $signed({24'b0, tu_r, 16'b0});
    case (msel_r)
      MUL_PA: begin
        mul_a = 34'(m1_r);
        mul_b = $signed({2'b0, a_r});
      end
      MUL_PB: begin
        mul_a = 34'(m2_r);
        mul_b = $signed({2'b0, pctp_pkg::ONE_Z}) - $signed({2'b0, b_r});
      end
      MUL_E1: begin
        mul_a = 34'(m1_r);
        mul_b = $signed({2'b0, h});
      end
      MUL_T2: begin
        mul_a = (34'(m1_r) <<< 1) - 34'(m2_r);
        mul_b = $signed({2'b0, h});
      end
      MUL_T3: begin
        mul_a = 34'(m1_r) - 34'(m2_r);
        mul_b = $signed({2'b0, h});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
    prod  = 56'(mul_p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tu_r   <= 16'd4800;
      tp_r   <= 16'd33600;
      zs_r   <= 17'd3604;
      a_r    <= 17'd1802;
      b_r    <= 17'd7209;
      st_r   <= ST_CHECK;
      dsel_r <= DIV_M1;
      dcnt_r <= 6'd0;
      msel_r <= MUL_PA;
      bad_r  <= 1'b0;
    end else begin
      case (st_r)
        ST_CHECK: begin
          if (degen) begin
            m1_r    <= '0;
            m2_r    <= '0;
            recip_r <= '0;
            for (int i = 0; i < 4; i++) c_r[i] <= '0;
            bad_r   <= 1'b1;
            st_r    <= ST_IDLE;
          end else begin
            bad_r  <= 1'b0;
            dsel_r <= DIV_M1;
            dcnt_r <= 6'd0;
            rem_r  <= '0;
            quo_r  <= dvd1;
            dvs_r  <= zs_r;
            dneg_r <= dt[16];
            st_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r  <= tr_ok ? tr[16:0] : {rem_r[15:0], quo_r[33]};
          quo_r  <= q_fin;
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd33) begin
            dcnt_r <= 6'd0;
            rem_r  <= '0;
            case (dsel_r)
              DIV_M1: begin
                m1_r   <= m_val;
                dsel_r <= DIV_M2;
                quo_r  <= dvd2;
                dvs_r  <= den2_abs[16:0];
                dneg_r <= dt[16] ^ den2[17];
              end
              DIV_M2: begin
                m2_r   <= m_val;
                dsel_r <= DIV_RC;
                quo_r  <= 34'h2_0000_0000;
                dvs_r  <= h;
              end
              default: begin
                recip_r <= q_fin;
                msel_r  <= MUL_PA;
                st_r    <= ST_MUL;
              end
            endcase
          end
        end
        ST_MUL: begin
          case (msel_r)
            MUL_PA:  pa_r <= prod;
            MUL_PB:  pb_r <= prod;
            MUL_E1:  e1_r <= prod;
            MUL_T2:  t2_r <= prod;
            default: t3_r <= prod;
          endcase
          msel_r <= msel_r + 3'd1;
          if (msel_r == MUL_T3) st_r <= ST_PAB;
        end
        ST_PAB: begin
          pa_r <= tu56 + pa_r;
          pb_r <= tu56 + pb_r;
          st_r <= ST_D;
        end
        ST_D: begin
          d_r  <= pb_r - pa_r;
          st_r <= ST_E;
        end
        ST_E: begin
          e_r[0] <= pa_r;
          e_r[1] <= e1_r;
          e_r[2] <= (d_r <<< 1) + d_r - t2_r;
          e_r[3] <= t3_r - (d_r <<< 1);
          st_r   <= ST_RND;
        end
        ST_RND: begin
          for (int i = 0; i < 4; i++) c_r[i] <= rcoef(e_r[i]);
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          REG_TU:  tu_r <= cfg_wdata[15:0];
          REG_TP:  tp_r <= cfg_wdata[15:0];
          REG_ZS:  zs_r <= cfg_wdata;
          REG_BS:  a_r  <= cfg_wdata;
          REG_BE:  b_r  <= cfg_wdata;
          default: ;
        endcase
        if (cfg_index <= REG_BE) st_r <= ST_CHECK;
      end
    end
  end

  assign busy       = (st_r != ST_IDLE);
  assign coef.tu    = tu_r;
  assign coef.m1    = m1_r;
  assign coef.m2    = m2_r;
  assign coef.recip = recip_r;
  assign coef.c0    = c_r[0];
  assign coef.c1    = c_r[1];
  assign coef.c2    = c_r[2];
  assign coef.c3    = c_r[3];
  assign coef.bad   = bad_r;
  assign bnd.a      = a_r;
  assign bnd.b      = b_r;

endmodule

/* sv/pctp_front.sv */
// front end: clamps and classifies each mixture fraction word
// holds the short queue toward the evaluator; depends on pctp_pkg
`timescale 1ns / 1ps

module pctp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic signed [pctp_pkg::IW-1:0] in_z,
  output logic                          in_full,
  input  logic                          busy,
  input  pctp_pkg::bounds_t             bnd,
  output logic                          mq_empty,
  output pctp_pkg::mq_word_t            mq_head,
  input  logic                          mq_pop
);

  pctp_pkg::mq_word_t mq_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic [pctp_pkg::ZW-1:0] zc;
  pctp_pkg::mq_word_t wd;
  logic push_ok;

  always_comb begin
    if (in_z[pctp_pkg::IW-1]) zc = '0;
    else if (in_z > $signed(20'sd65536)) zc = pctp_pkg::ONE_Z;
    else zc = in_z[pctp_pkg::ZW-1:0];
    if (zc < bnd.a) begin
      wd.br = pctp_pkg::BR_LEFT;
      wd.x  = zc;
    end else if (zc < bnd.b) begin
      wd.br = pctp_pkg::BR_BLEND;
      wd.x  = zc - bnd.a;
    end else begin
      wd.br = pctp_pkg::BR_RIGHT;
      wd.x  = pctp_pkg::ONE_Z - zc;
    end
  end

  assign in_full  = busy || (cnt_r == 3'd4);
  assign push_ok  = in_push && !in_full;
  assign mq_empty = (cnt_r == 3'd0);
  assign mq_head  = mq_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) mq_r[wp_r] <= wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= wp_r + 2'd1;
      if (mq_pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, push_ok} - {2'b0, mq_pop};
    end
  end

endmodule

/* sv/pctp_back.sv */
// back end: line and horner pipeline with result queue
// credit counter keeps the pipeline from overrunning the queue; depends on pctp_pkg
`timescale 1ns / 1ps

module pctp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pctp_pkg::coef_t                 coef,
  input  logic                            mq_empty,
  input  pctp_pkg::mq_word_t              mq_head,
  output logic                            mq_pop,
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic [pctp_pkg::TW-1:0]         out_temperature,
  output logic signed [pctp_pkg::SLW-1:0] out_slope,
  output logic                            out_params_invalid
);

  localparam int AW = 46;
  localparam int PW = 63;
  localparam int SW = 56;
  localparam int LW = 36;
  localparam logic [4:0] ODEPTH = 5'd16;

  function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] x);
    return x[AW-1] ? AW'(-x) : AW'(x);
  endfunction

  function automatic logic signed [AW-1:0] rnd16(input logic [PW-1:0] p, input logic n);
    logic [PW:0] sm;
    logic [AW-1:0] r;
    sm = {1'b0, p} + 64'h8000;
    r  = sm[AW+15:16];
    return n ? -$signed(r) : $signed(r);
  endfunction

  logic issue, pop_ok;
  logic [4:0] credit_r;
  logic [8:1] v_r;
  logic [1:0] br_r [1:8];
  logic signed [32:0] lsl_r [1:8];
  logic signed [LW-1:0] lt_r [2:8];
  logic [16:0] u_r [2:6];

  logic [48:0] lm1_r;
  logic        ln1_r;
  logic [50:0] up1_r;
  logic [PW-1:0] p3_r, q3_r, p5_r, q5_r, p7_r, ql7_r, qh7_r;
  logic        p3n_r, q3n_r, p5n_r, q5n_r, p7n_r, q7n_r;
  logic signed [AW-1:0] a4_r, q4_r, a6_r, q6_r, a8_r;
  logic signed [SW-1:0] sl8_r;

  logic [31:0] m_mag;
  logic signed [31:0] m_sel;
  logic [51:0] usum;
  logic [49:0] lsum;
  logic [32:0] lr;
  logic signed [AW-1:0] c0e, c1e, c2e, c3e, c3x3;
  logic [79:0] ssum;
  logic [54:0] sr;
  logic [AW:0] tsum;
  logic [AW-1:0] a8m;
  logic signed [AW-1:0] t_bl, t_sel;
  logic signed [SW-1:0] s_sel;
  logic [pctp_pkg::TW-1:0] t_fin;
  logic signed [pctp_pkg::SLW-1:0] s_fin;

  logic [pctp_pkg::TW-1:0] ot_r [16];
  logic signed [pctp_pkg::SLW-1:0] os_r [16];
  logic oi_r [16];
  logic [3:0] owp_r, orp_r;
  logic [4:0] ocnt_r;

  assign issue  = !mq_empty && (credit_r < ODEPTH);
  assign mq_pop = issue;
  assign pop_ok = out_pop && !out_empty;

  always_comb begin
    m_sel = (mq_head.br == pctp_pkg::BR_RIGHT) ? coef.m2 : coef.m1;
    m_mag = m_sel[31] ? 32'(-m_sel) : 32'(m_sel);
    usum  = {1'b0, up1_r} + 52'h1_0000;
    lsum  = {1'b0, lm1_r} + 50'h8000;
    lr    = lsum[48:16];
    c0e   = AW'(coef.c0);
    c1e   = AW'(coef.c1);
    c2e   = AW'(coef.c2);
    c3e   = AW'(coef.c3);
    c3x3  = c3e + (c3e <<< 1);
    ssum  = {qh7_r, 17'b0} + {17'b0, ql7_r} + 80'h100_0000;
    sr    = ssum[79:25];
    a8m   = mag(a8_r);
    tsum  = {1'b0, a8m} + 47'd128;
    t_bl  = a8_r[AW-1] ? -$signed({7'b0, tsum[AW:8]}) : $signed({7'b0, tsum[AW:8]});
    if (br_r[8] == pctp_pkg::BR_BLEND) begin
      t_sel = t_bl;
      s_sel = sl8_r;
    end else begin
      t_sel = AW'(lt_r[8]);
      s_sel = SW'(lsl_r[8]);
    end
    if (t_sel < 0) t_fin = '0;
    else if (t_sel > $signed(46'd65535)) t_fin = 16'hFFFF;
    else t_fin = t_sel[15:0];
    if (s_sel < $signed(-56'sd8388608)) s_fin = 24'sh800000;
    else if (s_sel > $signed(56'sd8388607)) s_fin = 24'sh7FFFFF;
    else s_fin = s_sel[23:0];
    if (coef.bad) begin
      t_fin = coef.tu;
      s_fin = '0;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: line product and blend position product
    br_r[1]  <= mq_head.br;
    lm1_r    <= m_mag * mq_head.x;
    ln1_r    <= m_sel[31];
    up1_r    <= mq_head.x * coef.recip;
    lsl_r[1] <= (mq_head.br == pctp_pkg::BR_RIGHT) ? -33'(coef.m2) : 33'(coef.m1);
    // stage 2: u and line temperature
    br_r[2]  <= br_r[1];
    lsl_r[2] <= lsl_r[1];
    u_r[2]   <= usum[33:17];
    lt_r[2]  <= ln1_r ? $signed({20'b0, coef.tu}) - $signed({3'b0, lr})
                      : $signed({20'b0, coef.tu}) + $signed({3'b0, lr});
    // stage 3
    p3_r  <= mag(c3e) * u_r[2];
    p3n_r <= c3e[AW-1];
    q3_r  <= mag(c3x3) * u_r[2];
    q3n_r <= c3x3[AW-1];
    // stage 4
    a4_r <= rnd16(p3_r, p3n_r) + c2e;
    q4_r <= rnd16(q3_r, q3n_r) + (c2e <<< 1);
    // stage 5
    p5_r  <= mag(a4_r) * u_r[4];
    p5n_r <= a4_r[AW-1];
    q5_r  <= mag(q4_r) * u_r[4];
    q5n_r <= q4_r[AW-1];
    // stage 6
    a6_r <= rnd16(p5_r, p5n_r) + c1e;
    q6_r <= rnd16(q5_r, q5n_r) + c1e;
    // stage 7
    p7_r  <= mag(a6_r) * u_r[6];
    p7n_r <= a6_r[AW-1];
    ql7_r <= mag(q6_r) * coef.recip[16:0];
    qh7_r <= mag(q6_r) * coef.recip[33:17];
    q7n_r <= q6_r[AW-1];
    // stage 8
    a8_r  <= rnd16(p7_r, p7n_r) + c0e;
    sl8_r <= q7n_r ? -$signed({1'b0, sr}) : $signed({1'b0, sr});
    for (int k = 3; k <= 8; k++) begin
      br_r[k]  <= br_r[k-1];
      lsl_r[k] <= lsl_r[k-1];
      lt_r[k]  <= lt_r[k-1];
    end
    for (int k = 3; k <= 6; k++) u_r[k] <= u_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (v_r[8]) begin
      ot_r[owp_r] <= t_fin;
      os_r[owp_r] <= s_fin;
      oi_r[owp_r] <= coef.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      credit_r <= '0;
      owp_r    <= '0;
      orp_r    <= '0;
      ocnt_r   <= '0;
    end else begin
      v_r      <= {v_r[7:1], issue};
      credit_r <= credit_r + {4'b0, issue} - {4'b0, pop_ok};
      if (v_r[8]) owp_r <= owp_r + 4'd1;
      if (pop_ok) orp_r <= orp_r + 4'd1;
      ocnt_r   <= ocnt_r + {4'b0, v_r[8]} - {4'b0, pop_ok};
    end
  end

  assign out_empty          = (ocnt_r == 5'd0);
  assign out_temperature    = ot_r[orp_r];
  assign out_slope          = os_r[orp_r];
  assign out_params_invalid = oi_r[orp_r];

endmodule

/* sv/piecewise_cubic_temperature_profile.sv */
// piecewise cubic temperature profile, top level; depends on pctp_pkg and pctp_cfg/front/back
// a pushed word passes the 4-word front queue, the 8-stage horner pipeline and the result queue
// to the ports; one word per cycle while the sequencer is idle and the result queue is popped
// after reset and after each config write to indices 0 to 4 the coefficient sequencer runs
// (three divisions, five products, four combine steps) with in_full held high
// reset loads the default profile registers and empties both queues
`timescale 1ns / 1ps

module piecewise_cubic_temperature_profile (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic signed [pctp_pkg::IW-1:0]  in_z,
  output logic                            in_full,
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic [pctp_pkg::TW-1:0]         out_temperature,
  output logic signed [pctp_pkg::SLW-1:0] out_slope,
  output logic                            out_params_invalid,
  input  logic                            cfg_we,
  input  logic [pctp_pkg::CIW-1:0]        cfg_index,
  input  logic [pctp_pkg::CDW-1:0]        cfg_wdata
);

  logic busy;
  pctp_pkg::coef_t    coef;
  pctp_pkg::bounds_t  bnd;
  logic mq_empty, mq_pop;
  pctp_pkg::mq_word_t mq_head;

  pctp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .coef      (coef),
    .bnd       (bnd)
  );

  pctp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_z     (in_z),
    .in_full  (in_full),
    .busy     (busy),
    .bnd      (bnd),
    .mq_empty (mq_empty),
    .mq_head  (mq_head),
    .mq_pop   (mq_pop)
  );

  pctp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .coef               (coef),
    .mq_empty           (mq_empty),
    .mq_head            (mq_head),
    .mq_pop             (mq_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_temperature    (out_temperature),
    .out_slope          (out_slope),
    .out_params_invalid (out_params_invalid)
  );

endmodule
